// File: src/slq_pkg.sv
// shared types and constants of the stepper line queue step generator
`timescale 1ns / 1ps

package slq_pkg;

    localparam int NUM_TICKS_W = 20;
    localparam int DELTA_W     = 21;
    localparam int FLAG_W      = 8;
    localparam int DEC_W       = 24;
    localparam int QCOUNT_W    = 9;
    localparam int THRESH_W    = 9;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd100;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                   cmd;
        logic [NUM_TICKS_W-1:0] num_ticks;
        logic [DELTA_W-1:0]     dx_doubled;
        logic [DELTA_W-1:0]     dy_doubled;
        logic [FLAG_W-1:0]      dir_or_action;
    } t_in_item;

    typedef struct packed {
        logic                push_accepted;
        logic                step_x;
        logic                step_y;
        logic                dir_x;
        logic                dir_y;
        logic                action_valid;
        logic [FLAG_W-1:0]   action_bits;
        logic                line_started;
        logic                busy_res;
        logic [QCOUNT_W-1:0] queue_count;
        logic                room_available;
    } t_out_item;

endpackage

// File: src/stepper_line_queue_step_generator.sv
// top level: line queue and two-axis dda step generator
`timescale 1ns / 1ps
//
// usage
//   input channel (i_in_valid / o_in_stall / i_in_item): each item is either
//   a push of one line entry or one timer tick. a push enters the queue unless
//   it is full. a tick pops the next entry when the current line has run out
//   (action entries report their byte, line entries load the dda), then runs
//   one dda round that gives at most one step per axis.
//   output channel (o_out_valid / i_out_stall / o_out_item): exactly one
//   result item per accepted input item, in order.
//   config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): room threshold,
//   always ready; only to be written while the block is idle, not enforced.
// latency and throughput
//   a result appears in the cycle after its item is accepted. one item per
//   cycle unless the receiver stalls: the queue head is prefetched from the
//   memory each cycle, so back-to-back pops of action entries need no wait.
// reset and stall
//   synchronous reset empties the queue, clears the line state and sets the
//   threshold to 100. when the receiver stalls, the result register holds and
//   the input stalls only while that register is full and not taken.
//

module stepper_line_queue_step_generator
    import slq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256,
    parameter int TICK_BITS   = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [THRESH_W-1:0] i_cfg_data
);

    localparam int TW   = TICK_BITS;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int EW   = TW + FLAG_W + 2 * DELTA_W;
    // decision arithmetic width: covers dec - 2*ticks + delta without wrap
    localparam int SW   = ((TW + 1) > DEC_W - 1 ? (TW + 1) : DEC_W - 1) + 2;
    localparam int CMPW = CW > THRESH_W ? CW : THRESH_W;

    // saturate to the signed decision range
    function automatic logic [DEC_W-1:0] clamp_dec(input logic [SW-1:0] v);
        logic [DEC_W-1:0] res;
        if (v[SW-1:DEC_W-1] == '0 || v[SW-1:DEC_W-1] == '1) begin
            res = v[DEC_W-1:0];
        end else if (v[SW-1]) begin
            res = {1'b1, {(DEC_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(DEC_W-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic logic [SW-1:0] sext_dec(input logic [DEC_W-1:0] d);
        return {{(SW-DEC_W){d[DEC_W-1]}}, d};
    endfunction

    // handshake
    logic acc, is_push, is_tick, push_en, pop;

    // queue
    logic [EW-1:0]      wdata, head;
    logic [CW-1:0]      count, count_next;
    logic [TW-1:0]      in_ticks;
    logic [TW-1:0]      h_ticks;
    logic [FLAG_W-1:0]  h_flags;
    logic [DELTA_W-1:0] h_dx, h_dy;

    // line state
    logic [TW-1:0]      r_ticks_left, n_ticks_left;
    logic [TW-1:0]      r_cur_t;
    logic [DELTA_W-1:0] r_cur_dx, r_cur_dy;
    logic [DEC_W-1:0]   r_dec_x, r_dec_y;
    logic [1:0]         r_dir;
    logic [THRESH_W-1:0] r_thresh;

    // values after a possible load
    logic               load, act, run, sx, sy;
    logic [TW-1:0]      a_ticks, a_t;
    logic [DELTA_W-1:0] a_dx, a_dy;
    logic [DEC_W-1:0]   a_dec_x, a_dec_y, n_dec_x, n_dec_y;
    logic [1:0]         a_dir;
    logic [SW-1:0]      dt2, sum_x, sum_y;
    logic [CMPW-1:0]    free_slots;

    t_out_item r_out, n_out;
    logic      r_out_valid;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign acc     = i_in_valid && !o_in_stall;
    assign is_push = acc && (i_in_item.cmd == CMD_PUSH);
    assign is_tick = acc && (i_in_item.cmd == CMD_TICK);
    assign push_en = is_push && (count < CW'(QUEUE_DEPTH));
    assign pop     = is_tick && (r_ticks_left == '0) && (count != '0);

    assign in_ticks = TW'(i_in_item.num_ticks);
    assign wdata    = {in_ticks, i_in_item.dir_or_action,
                       i_in_item.dx_doubled, i_in_item.dy_doubled};
    assign {h_ticks, h_flags, h_dx, h_dy} = head;

    slq_line_fifo #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (EW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_en),
        .i_wdata (wdata),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (count)
    );

    always_comb begin
        load = pop && (h_ticks != '0);
        act  = pop && (h_ticks == '0);

        // a fresh line loads dx2 - t and dy2 - t
        if (load) begin
            a_ticks = h_ticks;
            a_t     = h_ticks;
            a_dx    = h_dx;
            a_dy    = h_dy;
            a_dec_x = clamp_dec(SW'(h_dx) - SW'(h_ticks));
            a_dec_y = clamp_dec(SW'(h_dy) - SW'(h_ticks));
            a_dir   = h_flags[1:0];
        end else begin
            a_ticks = r_ticks_left;
            a_t     = r_cur_t;
            a_dx    = r_cur_dx;
            a_dy    = r_cur_dy;
            a_dec_x = r_dec_x;
            a_dec_y = r_dec_y;
            a_dir   = r_dir;
        end

        // one dda round: step on a positive decision, which then loses 2*ticks; every round adds the delta
        run   = is_tick && (a_ticks != '0);
        sx    = run && !a_dec_x[DEC_W-1] && (a_dec_x != '0);
        sy    = run && !a_dec_y[DEC_W-1] && (a_dec_y != '0);
        dt2   = SW'({a_t, 1'b0});
        sum_x = sext_dec(a_dec_x) - (sx ? dt2 : '0) + SW'(a_dx);
        sum_y = sext_dec(a_dec_y) - (sy ? dt2 : '0) + SW'(a_dy);
        n_dec_x = run ? clamp_dec(sum_x) : a_dec_x;
        n_dec_y = run ? clamp_dec(sum_y) : a_dec_y;
        n_ticks_left = run ? a_ticks - TW'(1) : a_ticks;

        if (push_en) begin
            count_next = count + CW'(1);
        end else if (pop) begin
            count_next = count - CW'(1);
        end else begin
            count_next = count;
        end
        free_slots = CMPW'(QUEUE_DEPTH) - CMPW'(count_next);

        n_out.push_accepted  = push_en;
        n_out.step_x         = sx;
        n_out.step_y         = sy;
        n_out.dir_x          = a_dir[0];
        n_out.dir_y          = a_dir[1];
        n_out.action_valid   = act;
        n_out.action_bits    = act ? h_flags : '0;
        n_out.line_started   = load;
        n_out.busy_res       = n_ticks_left != '0;
        n_out.queue_count    = QCOUNT_W'(count_next);
        n_out.room_available = free_slots > CMPW'(r_thresh);
    end

    // line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_left <= '0;
            r_cur_t      <= '0;
            r_cur_dx     <= '0;
            r_cur_dy     <= '0;
            r_dec_x      <= '0;
            r_dec_y      <= '0;
            r_dir        <= '0;
        end else if (is_tick) begin
            r_ticks_left <= n_ticks_left;
            r_dec_x      <= n_dec_x;
            r_dec_y      <= n_dec_y;
            if (load) begin
                r_cur_t  <= h_ticks;
                r_cur_dx <= h_dx;
                r_cur_dy <= h_dy;
                r_dir    <= h_flags[1:0];
            end
        end
    end

    // room threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thresh <= i_cfg_data;
        end
    end

    // result register, refilled in the cycle it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: src/slq_line_fifo.sv
// line entry queue in a synchronous memory with a prefetched head entry
`timescale 1ns / 1ps

module slq_line_fifo #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 70
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [DATA_W-1:0]          i_wdata,
    input  logic                       i_pop,
    output logic [DATA_W-1:0]          o_head,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [AW-1:0]     r_rp, n_rp;
    logic [AW-1:0]     r_wp, n_wp;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] r_fwd_data;
    logic              r_fwd;

    always_comb begin
        n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
        n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        if (i_push) begin
            n_count = r_count + CW'(1);
        end else if (i_pop) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
        // read ahead so the head register holds the entry at the read pointer
        rd_addr = i_pop ? n_rp : r_rp;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wp] <= i_wdata;
        end
        r_rdata    <= mem[rd_addr];
        r_fwd_data <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp    <= '0;
            r_wp    <= '0;
            r_count <= '0;
            r_fwd   <= 1'b0;
        end else begin
            // written entry is read in the same cycle: take it from the write side
            r_fwd   <= i_push && (r_wp == rd_addr);
            r_count <= n_count;
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push) begin
                r_wp <= n_wp;
            end
        end
    end

    assign o_head  = r_fwd ? r_fwd_data : r_rdata;
    assign o_count = r_count;

endmodule

// File: tb/sv/stepper_line_queue_step_generator_test.sv
// testbench of the stepper line queue step generator: line queue and dda step predictor, stimulus
`timescale 1ns / 1ps

import slq_pkg::*;

// tracks the line queue and the dda state, holds the expected result of every accepted item
class line_step_scoreboard;
    localparam int     SLOTS  = 256;
    localparam longint DEC_HI = 64'sd8388607;
    localparam longint DEC_LO = -64'sd8388608;

    logic [NUM_TICKS_W-1:0] slot_ticks [SLOTS];
    logic [FLAG_W-1:0]      slot_flags [SLOTS];
    logic [DELTA_W-1:0]     slot_dx [SLOTS];
    logic [DELTA_W-1:0]     slot_dy [SLOTS];
    int unsigned            head;
    int unsigned            tail;
    int unsigned            entries;
    logic [NUM_TICKS_W-1:0] ticks_left;
    logic [DELTA_W-1:0]     line_dt2;
    logic [DELTA_W-1:0]     line_dx2;
    logic [DELTA_W-1:0]     line_dy2;
    longint                 err_x;
    longint                 err_y;
    logic [1:0]             dir_held;
    logic [THRESH_W-1:0]    room_threshold;
    t_out_item              expected_steps[$];
    int unsigned            error_count;
    int unsigned            result_index;

    function new();
        head           = 0;
        tail           = 0;
        entries        = 0;
        ticks_left     = '0;
        line_dt2       = '0;
        line_dx2       = '0;
        line_dy2       = '0;
        err_x          = 0;
        err_y          = 0;
        dir_held       = '0;
        room_threshold = THRESH_RESET;
        error_count    = 0;
        result_index   = 0;
    endfunction

    function void set_threshold(logic [THRESH_W-1:0] value);
        room_threshold = value;
    endfunction

    function int unsigned pending();
        return expected_steps.size();
    endfunction

    // decision variables live in a 24-bit signed register
    function longint saturate(longint v);
        if (v > DEC_HI) return DEC_HI;
        if (v < DEC_LO) return DEC_LO;
        return v;
    endfunction

    function void accept_item(t_in_item it);
        t_out_item want;
        longint    nx;
        longint    ny;
        want = '0;
        if (it.cmd == CMD_PUSH) begin
            if (entries < SLOTS) begin
                slot_ticks[tail] = it.num_ticks;
                slot_flags[tail] = it.dir_or_action;
                slot_dx[tail]    = it.dx_doubled;
                slot_dy[tail]    = it.dy_doubled;
                tail             = (tail + 1) % SLOTS;
                entries++;
                want.push_accepted = 1'b1;
            end
        end else begin
            if (ticks_left == 0 && entries > 0) begin
                if (slot_ticks[head] == 0) begin
                    want.action_valid = 1'b1;
                    want.action_bits  = slot_flags[head];
                end else begin
                    ticks_left = slot_ticks[head];
                    line_dt2   = {slot_ticks[head], 1'b0};
                    line_dx2   = slot_dx[head];
                    line_dy2   = slot_dy[head];
                    err_x      = saturate(longint'(slot_dx[head]) - longint'(slot_ticks[head]));
                    err_y      = saturate(longint'(slot_dy[head]) - longint'(slot_ticks[head]));
                    dir_held   = slot_flags[head][1:0];
                    want.line_started = 1'b1;
                end
                head = (head + 1) % SLOTS;
                entries--;
            end
            if (ticks_left != 0) begin
                nx = err_x;
                ny = err_y;
                if (nx > 0) begin
                    want.step_x = 1'b1;
                    nx -= longint'(line_dt2);
                end
                nx += longint'(line_dx2);
                if (ny > 0) begin
                    want.step_y = 1'b1;
                    ny -= longint'(line_dt2);
                end
                ny += longint'(line_dy2);
                err_x = saturate(nx);
                err_y = saturate(ny);
                ticks_left--;
            end
        end
        want.dir_x          = dir_held[0];
        want.dir_y          = dir_held[1];
        want.busy_res       = (ticks_left != 0);
        want.queue_count    = QCOUNT_W'(entries);
        want.room_available = ((SLOTS - entries) > room_threshold);
        expected_steps.push_back(want);
    endfunction

    task report(string msg);
        $display("mismatch at result %0d: %s", result_index, msg);
        error_count++;
    endtask

    task compare_field(string name, logic [8:0] got, logic [8:0] want);
        if (got !== want) begin
            report($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task check_step(t_out_item got);
        t_out_item want;
        if (expected_steps.size() == 0) begin
            report("result with nothing expected");
            result_index++;
            return;
        end
        want = expected_steps.pop_front();
        compare_field("push_accepted", got.push_accepted, want.push_accepted);
        compare_field("step_x", got.step_x, want.step_x);
        compare_field("step_y", got.step_y, want.step_y);
        compare_field("dir_x", got.dir_x, want.dir_x);
        compare_field("dir_y", got.dir_y, want.dir_y);
        compare_field("action_valid", got.action_valid, want.action_valid);
        compare_field("action_bits", got.action_bits, want.action_bits);
        compare_field("line_started", got.line_started, want.line_started);
        compare_field("busy_res", got.busy_res, want.busy_res);
        compare_field("queue_count", got.queue_count, want.queue_count);
        compare_field("room_available", got.room_available, want.room_available);
        result_index++;
    endtask
endclass

module stepper_line_queue_step_generator_test;

    localparam int CYCLE_LIMIT = 200000;
    // long receiver hold-off, enough to back up the input
    localparam int HOLD_CYCLES = 300;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    t_in_item            in_item   = '0;
    logic                out_stall = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [THRESH_W-1:0] cfg_data  = '0;
    logic                in_stall;
    logic                out_valid;
    t_out_item           out_item;
    logic                cfg_ready;

    // idling percentages of the current phase
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // hold-off requests from the main sequence, served by the receiver process
    int unsigned hold_req  = 0;
    int unsigned hold_ack  = 0;
    int unsigned hold_left = 0;

    int unsigned cycle_count = 0;

    line_step_scoreboard sb = new();

    stepper_line_queue_step_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: both handshakes sampled at the edge, results checked before the
    // item of the same edge is noted (its result cannot be out yet anyway)
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                sb.check_step(out_item);
            end
            if (in_valid && !in_stall) begin
                sb.accept_item(in_item);
            end
        end
    end

    function automatic t_in_item make_item(t_cmd cmd, logic [NUM_TICKS_W-1:0] ticks,
                                           logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy,
                                           logic [FLAG_W-1:0] flags);
        t_in_item it;
        it.cmd           = cmd;
        it.num_ticks     = ticks;
        it.dx_doubled    = dx;
        it.dy_doubled    = dy;
        it.dir_or_action = flags;
        return it;
    endfunction

    // tick items carry junk in every field but cmd, the block must ignore it
    function automatic t_in_item random_tick();
        return make_item(CMD_TICK, NUM_TICKS_W'($urandom), DELTA_W'($urandom),
                         DELTA_W'($urandom), FLAG_W'($urandom));
    endfunction

    // mostly a real line (step count within the tick count), sometimes far too many steps
    function automatic logic [DELTA_W-1:0] random_delta(logic [NUM_TICKS_W-1:0] ticks);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) return DELTA_W'($urandom_range(2 * ticks, 0));
        if (pick < 90) return DELTA_W'($urandom);
        return '0;
    endfunction

    // short lines keep the queue moving; about a third are action entries
    function automatic t_in_item random_entry();
        logic [NUM_TICKS_W-1:0] ticks;
        int unsigned            pick;
        pick = $urandom_range(99);
        if (pick < 35) ticks = '0;
        else if (pick < 97) ticks = NUM_TICKS_W'($urandom_range(4, 1));
        else ticks = NUM_TICKS_W'($urandom_range(40, 9));
        return make_item(CMD_PUSH, ticks, random_delta(ticks), random_delta(ticks),
                         FLAG_W'($urandom));
    endfunction

    // valid stays up from one item to the next unless the sender idles
    task automatic send_item(input t_in_item it);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random(input int unsigned count, input int unsigned push_pct);
        repeat (count) begin
            if ($urandom_range(99) < push_pct) send_item(random_entry());
            else send_item(random_tick());
        end
    endtask

    // sender goes quiet until every result is in
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // only called while nothing is in flight
    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_threshold(value);
        repeat (2) @(posedge clk);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset threshold
        // tick on an empty queue, all junk bits set
        send_item(make_item(CMD_TICK, '1, '1, '1, '1));
        // two action entries, all flags set and none
        send_item(make_item(CMD_PUSH, '0, '1, '1, 8'hff));
        send_item(make_item(CMD_PUSH, '0, '0, '0, 8'h00));
        // one-tick line, x positive
        send_item(make_item(CMD_PUSH, 20'd1, 21'd2, 21'd0, 8'h01));
        // far more steps than ticks on both axes: decision variables saturate
        send_item(make_item(CMD_PUSH, 20'd6, '1, '1, 8'h02));
        // y steps every tick, x never
        send_item(make_item(CMD_PUSH, 20'd4, 21'd0, 21'd8, 8'h03));
        send_item(make_item(CMD_PUSH, 20'd3, 21'd2, 21'd4, 8'hfc));
        // pop both actions, then run every line out; one pop per tick
        repeat (16) send_item(random_tick());
        // finished line and empty queue: nothing happens
        send_item(random_tick());
        wait_for_results();

        // phase without idling: fill past full, then a long receiver hold-off
        write_threshold('0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (260) send_item(random_entry());
        hold_req <= hold_req + 1;
        send_random(350, 10);
        wait_for_results();

        // sender idling, threshold at the queue depth so room never shows
        write_threshold(THRESH_W'(256));
        send_idle_pct  = 62;
        recv_stall_pct = 0;
        send_random(100, 10);
        // sender pauses mid-phase until the block has drained
        wait_for_results();
        send_random(100, 10);
        wait_for_results();

        // receiver stalling
        write_threshold(THRESH_W'($urandom_range(255, 1)));
        send_idle_pct  = 0;
        recv_stall_pct = 62;
        send_random(200, 10);
        wait_for_results();

        // both sides idling
        write_threshold(THRESH_RESET);
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        send_random(200, 10);
        wait_for_results();

        // run the queue dry so the longest line below really loads
        while (sb.entries != 0 || sb.ticks_left != 0) begin
            repeat (8) send_item(random_tick());
            wait_for_results();
        end
        send_item(make_item(CMD_PUSH, '1, '1, '0, 8'h01));
        send_item(make_item(CMD_PUSH, NUM_TICKS_W'($urandom), DELTA_W'($urandom),
                            DELTA_W'($urandom), FLAG_W'($urandom)));
        repeat (20) send_item(random_tick());
        wait_for_results();
        repeat (5) @(posedge clk);

        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
